FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BFM_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BFM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Types, constants and helpers shared by the focus measure block.
// ----------------------------------------------------------------------------
package bfm_pkg;

   // Frame size limits.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int CFG_W  = 13;
   localparam int DIM_W  = CFG_W + 1;
   localparam int SUM_W  = 40;
   localparam int Q8_W   = 24;
   localparam int FRAC_W = 8;
   localparam int SQ_W   = 2 * PIX_W;

   // Counter and line store widths.
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int LS_DEPTH  = 2 * MAX_WIDTH;
   localparam int LS_ADDR_W = $clog2(LS_DEPTH);

   // Gray conversion weights in Q16.
   localparam int WGT_W  = 16;
   localparam int PROD_W = PIX_W + WGT_W;
   localparam int GSUM_W = PROD_W + 2;
   localparam logic [WGT_W-1:0] GRAY_WGT0 = 16'd19595;
   localparam logic [WGT_W-1:0] GRAY_WGT1 = 16'd38470;
   localparam logic [WGT_W-1:0] GRAY_WGT2 = 16'd7471;

   // Divider widths.
   localparam int DVD_W = SUM_W + FRAC_W;
   localparam int DVS_W = 2 * DIM_W;
   localparam int DCNT_W = $clog2(DVD_W);

   // Register defaults.
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   // Register indexes.
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Input word: one pixel.
   typedef struct packed {
      logic [PIX_W-1:0] pixel_byte0;
      logic [PIX_W-1:0] pixel_byte1;
      logic [PIX_W-1:0] pixel_byte2;
   } req_word_type;

   // Result word: one per frame.
   typedef struct packed {
      logic [Q8_W-1:0]  clarity_q8;
      logic [SUM_W-1:0] squared_diff_sum;
   } rsp_word_type;

   // Zero counts as one, anything above the limit counts as the limit.
   function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v,
                                                  logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] ext;
      ext = DIM_W'(v);
      if (ext == '0) begin
         return DIM_W'(1);
      end else if (ext > maxv) begin
         return maxv;
      end else begin
         return ext;
      end
   endfunction

endpackage

FILE: hdl/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bfm_div.sv
// ----------------------------------------------------------------------------
// bfm_div
// Restoring divider, one quotient bit per cycle, for the frame mean.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bfm_pkg::DVD_W-1:0] dividend,
   input  logic [bfm_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [bfm_pkg::DVD_W-1:0] quotient
);
   import bfm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    trial_sub;
   logic              fits;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign trial     = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DVD_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `BFM_ASSERT(a_div_no_restart, start, !busy_ff, "divider started while busy")
   `BFM_ASSERT(a_div_done_after_busy, done_ff, !busy_ff && $past(busy_ff),
      "divider done without a running division")

endmodule

FILE: hdl/brenner_focus_measure_top.sv
// ----------------------------------------------------------------------------
// brenner_focus_measure_top
// Brenner focus measure over a raster stream of 24-bit pixels.
// ----------------------------------------------------------------------------
// Each accepted pixel passes through the product with the line store read,
// the gray sum, the squared difference with the line store write-back, and
// the accumulate. The line store is one RAM with a registered read, and each
// pixel reads and then rewrites its own slot. After the last pixel of a frame,
// the bit-serial divider forms the mean and raises its done flag, and the result
// is loaded into the output register once that register is empty or its word
// is being taken. The next frame's first pixel is taken as soon as that
// register is loaded, even while the result still waits to be taken.
// Frame size is set through csr register 0 (width) and 1 (height); the user
// must change it only between frames, which the block itself does not enforce.
`include "assert_macros.svh"

module brenner_focus_measure_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bfm_pkg::req_word_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bfm_pkg::rsp_word_type       rsp_data,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [bfm_pkg::CFG_W-1:0]   csr_wdata
);
   import bfm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_GRAY = 6'b000010,
      S_DIFF = 6'b000100,
      S_SUM  = 6'b001000,
      S_DIV  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [PROD_W-1:0] prod0_ff, prod1_ff, prod2_ff;
   logic [PIX_W-1:0]  gray_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [SUM_W-1:0]  frame_sum_ff;
   rsp_word_type      rsp_data_ff;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [LS_ADDR_W-1:0] slot;
   logic [PIX_W-1:0]  above;
   logic [GSUM_W-1:0] gray_sum;
   logic [PIX_W-1:0]  diff;
   logic [SUM_W:0]    acc_sum;
   logic [SUM_W-1:0]  acc_sat;
   logic              col_last, row_last, frame_end;
   logic              req_take, rsp_take, rsp_load;
   logic              div_start, div_done;
   logic [DVD_W-1:0]  div_quo;
   logic [DVS_W-1:0]  pix_count;
   logic [Q8_W-1:0]   mean_sat;

   // Frame size in force.
   assign w_eff = clamp_dim(width_ff, DIM_W'(MAX_WIDTH));
   assign h_eff = clamp_dim(height_ff, DIM_W'(MAX_HEIGHT));

   // Handshakes.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Line store slot: the row parity picks the half, the column the entry.
   assign slot = row_ff[0] ? (LS_ADDR_W'(MAX_WIDTH) + LS_ADDR_W'(col_ff))
                           : LS_ADDR_W'(col_ff);

   bfm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LS_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (state_ff == S_DIFF),
      .wr_addr (slot),
      .wr_data (gray_ff),
      .rd_en   (req_take),
      .rd_addr (slot),
      .rd_data (above)
   );

   // Gray sum and absolute two-row difference.
   assign gray_sum = GSUM_W'(prod0_ff) + GSUM_W'(prod1_ff) + GSUM_W'(prod2_ff);
   assign diff     = (gray_ff > above) ? (gray_ff - above) : (above - gray_ff);

   // Saturating accumulate.
   assign acc_sum = {1'b0, acc_ff} + (SUM_W + 1)'(sq_ff);
   assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

   // Row and frame end.
   assign col_last  = (DIM_W'(col_ff) + DIM_W'(1)) >= w_eff;
   assign row_last  = (DIM_W'(row_ff) + DIM_W'(1)) >= h_eff;
   assign frame_end = col_last && row_last;
   assign div_start = (state_ff == S_SUM) && frame_end;
   assign pix_count = DVS_W'(w_eff) * DVS_W'(h_eff);

   bfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({acc_in, FRAC_W'(0)}),
      .divisor  (pix_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign mean_sat = (|div_quo[DVD_W-1:Q8_W]) ? '1 : div_quo[Q8_W-1:0];

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer, counters and accumulator.
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_GRAY;
            end
         end
         S_GRAY: state_in = S_DIFF;
         S_DIFF: state_in = S_SUM;
         S_SUM: begin
            if (|row_ff[ROW_W-1:1]) begin
               acc_in = acc_sat;
            end
            if (!col_last) begin
               col_in   = col_ff + COL_W'(1);
               state_in = S_IDLE;
            end else if (!row_last) begin
               col_in   = '0;
               row_in   = row_ff + ROW_W'(1);
               state_in = S_IDLE;
            end else begin
               col_in   = '0;
               row_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         acc_ff       <= div_start ? '0 : acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         prod0_ff <= PROD_W'(req_data.pixel_byte0) * PROD_W'(GRAY_WGT0);
         prod1_ff <= PROD_W'(req_data.pixel_byte1) * PROD_W'(GRAY_WGT1);
         prod2_ff <= PROD_W'(req_data.pixel_byte2) * PROD_W'(GRAY_WGT2);
      end
      if (state_ff == S_GRAY) begin
         gray_ff <= gray_sum[WGT_W +: PIX_W];
      end
      if (state_ff == S_DIFF) begin
         sq_ff <= SQ_W'(diff) * SQ_W'(diff);
      end
      if (div_start) begin
         frame_sum_ff <= acc_in;
      end
      if (rsp_load) begin
         rsp_data_ff.clarity_q8       <= mean_sat;
         rsp_data_ff.squared_diff_sum <= frame_sum_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BFM_ASSERT(a_start_in_sum, div_start, state_ff == S_SUM,
      "mean division started outside the accumulate step")
   `BFM_ASSERT_NXT(a_acc_cleared, div_start, acc_ff == '0,
      "accumulator not cleared at frame end")
   `BFM_ASSERT(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff == S_OUT),
      "result word loaded outside the output step")

endmodule

FILE: sim/tb_brenner_focus_measure_top.sv
// ----------------------------------------------------------------------------
// tb_brenner_focus_measure_top
// Self-checking bench for the Brenner focus measure block.
// ----------------------------------------------------------------------------
// Pixels stream in frame by frame while both handshakes see random gaps and
// stalls. A behavioral tracker of gray conversion, the two-row line store and
// the difference accumulator predicts the sum and Q8 mean of every frame, and
// each result word is compared field by field with the oldest prediction.
// Frame size changes only between frames, once all results are back.
// ----------------------------------------------------------------------------
module tb_brenner_focus_measure_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bfm_pkg::*;

   localparam int CFG_SETTLE_CYCLES = 8;
   localparam int END_CYCLES        = 80;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int RANDOM_PIXELS     = 1050;
   localparam int REPORT_LIMIT      = 10;

   typedef enum int {
      PIX_NOISE,
      PIX_SMOOTH,
      PIX_SATURATED
   } pixel_style_type;

   // Block ports.
   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_word_type    req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_word_type    rsp_data;
   logic            csr_we;
   logic [0:0]      csr_index;
   logic [CFG_W-1:0] csr_wdata;

   // Tracker state: registers, counters, accumulator and line store.
   logic [CFG_W-1:0] frame_width_reg  = WIDTH_RESET;
   logic [CFG_W-1:0] frame_height_reg = HEIGHT_RESET;
   int unsigned      track_col = 0;
   int unsigned      track_row = 0;
   logic [SUM_W-1:0] track_sum = '0;
   logic [7:0]       gray_rows [0:LS_DEPTH-1];

   // Results waiting to come out, and bookkeeping.
   rsp_word_type frame_results_due [$];
   int unsigned  pixels_sent   = 0;
   int unsigned  frames_seen   = 0;
   int unsigned  mismatches    = 0;
   int unsigned  idle_cycles   = 0;
   bit           steady_feed   = 1'b0;

   brenner_focus_measure_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Zero counts as one, anything above the limit counts as the limit.
   function automatic int unsigned effective_size(input logic [CFG_W-1:0] raw,
                                                  input int unsigned limit);
      if (raw == '0) begin
         return 1;
      end
      return (int'(raw) > limit) ? limit : int'(raw);
   endfunction

   // Q16 weighted luma, truncated to eight bits.
   function automatic logic [7:0] luma_of(input req_word_type px);
      int unsigned acc;
      acc = px.pixel_byte0 * 32'd19595 + px.pixel_byte1 * 32'd38470
          + px.pixel_byte2 * 32'd7471;
      return acc[23:16];
   endfunction

   // Advance the tracker by one pixel; queue the frame result at the last one.
   function automatic void track_pixel(input req_word_type px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      col;
      int unsigned      slot;
      logic [7:0]       g;
      logic [7:0]       above;
      logic [7:0]       d;
      logic [15:0]      sq;
      logic [SUM_W:0]   s;
      logic [63:0]      mean;
      rsp_word_type     r;
      w = effective_size(frame_width_reg, MAX_WIDTH);
      h = effective_size(frame_height_reg, MAX_HEIGHT);
      col = (track_col < MAX_WIDTH) ? track_col : MAX_WIDTH - 1;
      slot = (track_row % 2) * MAX_WIDTH + col;
      g = luma_of(px);
      if (track_row >= 2) begin
         above = gray_rows[slot];
         d = (g > above) ? g - above : above - g;
         sq = d * d;
         s = {1'b0, track_sum} + (SUM_W + 1)'(sq);
         track_sum = s[SUM_W] ? '1 : s[SUM_W-1:0];
      end
      gray_rows[slot] = g;
      if (track_col + 1 < w) begin
         track_col++;
         return;
      end
      track_col = 0;
      if (track_row + 1 < h) begin
         track_row++;
         return;
      end
      mean = {16'd0, track_sum, 8'd0} / (64'(w) * 64'(h));
      r.clarity_q8 = (mean > 64'hFF_FFFF) ? '1 : mean[Q8_W-1:0];
      r.squared_diff_sum = track_sum;
      frame_results_due.push_back(r);
      track_row = 0;
      track_sum = '0;
   endfunction

   // Mostly short gaps, a few long ones, none while feeding steadily.
   function automatic int unsigned next_gap();
      int unsigned pick;
      if (steady_feed) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] level);
      int unsigned v;
      v = level + $urandom_range(0, 5);
      return (v > 255) ? 8'hFF : v[7:0];
   endfunction

   function automatic req_word_type make_pixel(input pixel_style_type style,
                                               input logic [7:0] level);
      req_word_type px;
      case (style)
         PIX_NOISE: begin
            px = req_word_type'(24'($urandom));
         end
         PIX_SATURATED: begin
            px.pixel_byte0 = {8{1'($urandom)}};
            px.pixel_byte1 = {8{1'($urandom)}};
            px.pixel_byte2 = {8{1'($urandom)}};
         end
         default: begin
            px.pixel_byte0 = jitter(level);
            px.pixel_byte1 = jitter(level);
            px.pixel_byte2 = jitter(level);
         end
      endcase
      return px;
   endfunction

   // Send one word and wait for it to be taken, then maybe idle.
   task automatic send_pixel(input req_word_type px);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      track_pixel(px);
      pixels_sent++;
      gap = next_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop feeding and wait until every predicted result has come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      repeat (CFG_SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) begin
         frame_width_reg = value;
      end else begin
         frame_height_reg = value;
      end
   endtask

   task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      wait_for_results();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic send_frame(input pixel_style_type style);
      int unsigned count;
      logic [7:0]  level;
      count = effective_size(frame_width_reg, MAX_WIDTH)
            * effective_size(frame_height_reg, MAX_HEIGHT);
      level = 8'($urandom);
      repeat (count) send_pixel(make_pixel(style, level));
   endtask

   // Single-column frames isolate the gray conversion: the difference of the
   // third pixel against a black first pixel is its gray value squared.
   task automatic test_gray_weights();
      req_word_type probes [6];
      req_word_type black;
      probes[0] = {8'hFF, 8'h00, 8'h00};
      probes[1] = {8'h00, 8'hFF, 8'h00};
      probes[2] = {8'h00, 8'h00, 8'hFF};
      probes[3] = {8'hFF, 8'hFF, 8'hFF};
      probes[4] = {8'hAA, 8'hAA, 8'hAA};
      probes[5] = {8'h55, 8'h55, 8'h55};
      black = '0;
      set_frame_size(13'd1, 13'd3);
      foreach (probes[i]) begin
         send_pixel(black);
         send_pixel(make_pixel(PIX_NOISE, 8'd0));
         send_pixel(probes[i]);
      end
   endtask

   // Zero and short sizes: one-pixel frames and frames with no third row.
   task automatic test_degenerate_sizes();
      set_frame_size(13'd0, 13'd0);
      send_frame(PIX_SATURATED);
      send_frame(PIX_NOISE);
      set_frame_size(13'd5, 13'd1);
      send_frame(PIX_NOISE);
      set_frame_size(13'd3, 13'd2);
      send_frame(PIX_NOISE);
   endtask

   // Rows flip between black and white every two rows: every difference is full
   // scale.
   task automatic test_max_contrast();
      req_word_type px;
      set_frame_size(13'd4, 13'd6);
      for (int row = 0; row < 6; row++) begin
         for (int col = 0; col < 4; col++) begin
            px = ((row / 2) % 2 == 1) ? '1 : '0;
            send_pixel(px);
         end
      end
   endtask

   // A long row frame and a tall single-column frame.
   task automatic test_size_extremes();
      set_frame_size(13'd150, 13'd3);
      send_frame(PIX_NOISE);
      set_frame_size(13'd1, 13'd200);
      send_frame(PIX_SMOOTH);
   endtask

   // Groups of back-to-back frames of one random size and random content.
   task automatic test_random_frames();
      int unsigned   start;
      int unsigned   pick;
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            w = '0;
         end else if (pick < 60) begin
            w = CFG_W'($urandom_range(1, 8));
         end else if (pick < 90) begin
            w = CFG_W'($urandom_range(9, 20));
         end else begin
            w = CFG_W'($urandom_range(21, 40));
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            h = '0;
         end else if (pick < 15) begin
            h = CFG_W'($urandom_range(1, 2));
         end else if (pick < 40) begin
            h = 13'd3;
         end else begin
            h = CFG_W'($urandom_range(4, 8));
         end
         set_frame_size(w, h);
         steady_feed = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 4)) begin
            send_frame(pixel_style_type'($urandom_range(0, 2)));
         end
         steady_feed = 1'b0;
      end
   endtask

   // Result side stall pattern: long open stretches, mostly short stalls.
   initial begin
      int unsigned pick;
      rsp_stall <= 1'b0;
      repeat (3) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else if (pick < 88) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (pick < 98) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(4, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end
      end
   end

   // Compare each taken result word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected result word: clarity %0d sum %0d",
                        rsp_data.clarity_q8, rsp_data.squared_diff_sum);
            end
         end else begin
            want = frame_results_due.pop_front();
            if (want.clarity_q8 != rsp_data.clarity_q8 ||
                want.squared_diff_sum != rsp_data.squared_diff_sum) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("frame %0d: expected clarity %0d sum %0d, got clarity %0d sum %0d",
                           frames_seen, want.clarity_q8, want.squared_diff_sum,
                           rsp_data.clarity_q8, rsp_data.squared_diff_sum);
               end
            end
         end
         frames_seen++;
      end
   end

   // Watchdog: too long without any word moving on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("brenner_focus_measure_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_gray_weights();
      test_degenerate_sizes();
      test_max_contrast();
      test_size_extremes();
      test_random_frames();

      wait_for_results();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && frame_results_due.size() == 0) begin
         $display("brenner_focus_measure_top: match");
      end else begin
         $display("brenner_focus_measure_top: mismatch");
      end
      $finish;
   end

endmodule
